@@ rtl/rau_pkg.sv @@
// rau_pkg: shared types and codes of the rational arithmetic unit.
// Used by the interfaces, the controller, the datapath and the top level.
package rau_pkg;

    localparam int WIDTH_DEF = 32;
    localparam int DATA_W    = 32;
    localparam int DEN_W     = 31;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       form;
        logic       gcd_step;
        logic       div_init;
        logic       div_den;
        logic       div_step;
        logic       finish;
    } rau_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic gcd_done;
        logic div_done;
    } rau_sts_t;

endpackage

@@ rtl/rau_if.sv @@
// Valid/ready channels of the rational arithmetic unit: operand word and result word.
// Depends on rau_pkg for field widths.
interface rau_in_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          op;
    logic signed [rau_pkg::DATA_W-1:0]   a_num;
    logic signed [rau_pkg::DATA_W-1:0]   a_den;
    logic signed [rau_pkg::DATA_W-1:0]   b_num;
    logic signed [rau_pkg::DATA_W-1:0]   b_den;

    modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [rau_pkg::DATA_W-1:0]   res_num;
    logic [rau_pkg::DEN_W-1:0]           res_den;
    logic                                less;
    logic                                equal;
    logic                                greater;
    logic [1:0]                          status;

    modport source (output valid, res_num, res_den, less, equal, greater, status,
                    input ready);
    modport sink   (input valid, res_num, res_den, less, equal, greater, status,
                    output ready);
endinterface

@@ rtl/rational_arith_unit_top.sv @@
// Rational arithmetic unit: adds, subtracts, multiplies, divides or compares two
// fractions and returns the result in lowest terms with a positive denominator,
// together with less/equal/greater flags of a against b and a status code (ok,
// division by zero, result out of range). A zero denominator reads as 0/1; only
// the low WIDTH bits of each operand count. One word is worked at a time: the
// input is ready only while the unit is idle. An item forms four products on the
// shared WIDTH x WIDTH multiplier, combines them, then runs a binary GCD of one step
// a cycle (data dependent), then two restoring divisions (load, quotient bits until
// the count runs out) through one shared divider, and then posts the result. Results
// with a zero numerator, compares and division by zero skip GCD and division. A
// finished result sits in the output register, and the next word is taken while it
// waits to be read.
// Depends on rau_pkg, rau_if, rau_ctrl and rau_dp.
module rational_arith_unit_top
#(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    rau_in_if.sink    in,
    rau_out_if.source out
);

    rau_pkg::rau_cmd_t cmd;
    rau_pkg::rau_sts_t sts;

    // sequencing: handshakes, the multiplier step count and the output valid flag
    rau_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_ready (out.ready),
        .out_valid (out.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic: multiplier, GCD, divider and output payload
    rau_dp #(.WIDTH(WIDTH)) u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .op      (in.op),
        .a_num   (in.a_num),
        .a_den   (in.a_den),
        .b_num   (in.b_num),
        .b_den   (in.b_den),
        .res_num (out.res_num),
        .res_den (out.res_den),
        .less    (out.less),
        .equal   (out.equal),
        .greater (out.greater),
        .status  (out.status)
    );

    // one word in flight: after taking a word the input drops ready
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in.valid && in.ready |=> !in.ready)
        else $error("input ready while a word is in work");

    // exactly one compare flag on every result
    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> $onehot({out.less, out.equal, out.greater}))
        else $error("compare flags not one-hot");

    // errors return 0/1
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && out.status != rau_pkg::ST_OK |-> out.res_num == '0 && out.res_den == 1)
        else $error("error result is not 0/1");

    // a zero result is always 0/1, and the denominator never zero
    a_zero_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> out.res_den != '0 && (out.res_num != '0 || out.res_den == 1))
        else $error("result denominator not reduced");

endmodule

@@ rtl/rau_ctrl.sv @@
// rau_ctrl: sequencing state machine of the rational arithmetic unit.
// Depends on rau_pkg for the command and status structs.
module rau_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    input  rau_pkg::rau_sts_t sts,
    output rau_pkg::rau_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_FORM = 9'b000000100,
        S_GCD  = 9'b000001000,
        S_DN0  = 9'b000010000,
        S_DN   = 9'b000100000,
        S_DD0  = 9'b001000000,
        S_DD   = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] mul_cnt_reg, mul_cnt_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        mul_cnt_next   = mul_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    mul_cnt_next = 2'd0;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = mul_cnt_reg;
                mul_cnt_next = mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == 2'd3)
                    state_next = S_FORM;
            end
            S_FORM:
            begin
                cmd.form   = 1'b1;
                state_next = sts.skip ? S_FIN : S_GCD;
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                    state_next = S_DN0;
                else
                    cmd.gcd_step = 1'b1;
            end
            S_DN0:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DN;
            end
            S_DN:
            begin
                if (sts.div_done)
                    state_next = S_DD0;
                else
                    cmd.div_step = 1'b1;
            end
            S_DD0:
            begin
                cmd.div_init = 1'b1;
                cmd.div_den  = 1'b1;
                state_next   = S_DD;
            end
            S_DD:
            begin
                if (sts.div_done)
                    state_next = S_FIN;
                else
                    cmd.div_step = 1'b1;
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mul_cnt_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_cnt_reg   <= mul_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/rau_dp.sv @@
// rau_dp: datapath of the rational arithmetic unit: operand load, shared multiplier,
// combine, binary GCD, shared restoring divider and result register. Depends on rau_pkg.
module rau_dp
#(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  rau_pkg::rau_cmd_t                   cmd,
    output rau_pkg::rau_sts_t                   sts,
    input  logic [2:0]                          op,
    input  logic signed [rau_pkg::DATA_W-1:0]   a_num,
    input  logic signed [rau_pkg::DATA_W-1:0]   a_den,
    input  logic signed [rau_pkg::DATA_W-1:0]   b_num,
    input  logic signed [rau_pkg::DATA_W-1:0]   b_den,
    output logic signed [rau_pkg::DATA_W-1:0]   res_num,
    output logic [rau_pkg::DEN_W-1:0]           res_den,
    output logic                                less,
    output logic                                equal,
    output logic                                greater,
    output logic [1:0]                          status
);

    localparam int PW = 2 * WIDTH;
    localparam int KW = $clog2(PW);
    localparam int CW = $clog2(PW) + 1;
    localparam logic [PW-1:0] LIM = PW'((64'd1 << (WIDTH - 1)) - 64'd1);
    localparam logic [CW-1:0] DIV_STEPS = CW'(PW);

    // operand load
    logic [WIDTH-1:0] an_raw, ad_raw, bn_raw, bd_raw;
    logic [WIDTH-1:0] an_abs, ad_abs, bn_abs, bd_abs;
    logic [WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic             an_neg_reg, bn_neg_reg;
    logic [2:0]       op_reg;

    always_comb
    begin
        an_raw = a_num[WIDTH-1:0];
        ad_raw = a_den[WIDTH-1:0];
        bn_raw = b_num[WIDTH-1:0];
        bd_raw = b_den[WIDTH-1:0];
        an_abs = an_raw[WIDTH-1] ? (~an_raw + 1'b1) : an_raw;
        ad_abs = ad_raw[WIDTH-1] ? (~ad_raw + 1'b1) : ad_raw;
        bn_abs = bn_raw[WIDTH-1] ? (~bn_raw + 1'b1) : bn_raw;
        bd_abs = bd_raw[WIDTH-1] ? (~bd_raw + 1'b1) : bd_raw;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            if (ad_raw == '0)
            begin
                an_reg     <= '0;
                ad_reg     <= WIDTH'(1);
                an_neg_reg <= 1'b0;
            end
            else
            begin
                an_reg     <= an_abs;
                ad_reg     <= ad_abs;
                an_neg_reg <= (an_raw[WIDTH-1] ^ ad_raw[WIDTH-1]) && (an_abs != '0);
            end
            if (bd_raw == '0)
            begin
                bn_reg     <= '0;
                bd_reg     <= WIDTH'(1);
                bn_neg_reg <= 1'b0;
            end
            else
            begin
                bn_reg     <= bn_abs;
                bd_reg     <= bd_abs;
                bn_neg_reg <= (bn_raw[WIDTH-1] ^ bd_raw[WIDTH-1]) && (bn_abs != '0);
            end
        end
    end

    // shared multiplier: an*bd, bn*ad, ad*bd, an*bn
    logic [WIDTH-1:0] mul_a, mul_b;
    logic [PW-1:0]    prod_reg [4];

    always_comb
    begin
        unique case (cmd.mul_sel)
            2'd0:    begin mul_a = an_reg; mul_b = bd_reg; end
            2'd1:    begin mul_a = bn_reg; mul_b = ad_reg; end
            2'd2:    begin mul_a = ad_reg; mul_b = bd_reg; end
            default: begin mul_a = an_reg; mul_b = bn_reg; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg[cmd.mul_sel] <= PW'(mul_a) * PW'(mul_b);
    end

    // combine products into numerator and denominator
    logic [PW-1:0] p1, p2, p3, p4;
    logic          add_y_neg;
    logic [PW-1:0] sum_mag;
    logic          sum_neg;
    logic [PW-1:0] rn_mag, rd_mag;
    logic          rn_neg, no_arith, div0;
    logic          c_less, c_equal;

    always_comb
    begin
        p1 = prod_reg[0];
        p2 = prod_reg[1];
        p3 = prod_reg[2];
        p4 = prod_reg[3];

        add_y_neg = (op_reg == rau_pkg::OP_SUB) ? !bn_neg_reg : bn_neg_reg;
        if (an_neg_reg == add_y_neg)
        begin
            sum_mag = p1 + p2;
            sum_neg = an_neg_reg;
        end
        else if (p1 >= p2)
        begin
            sum_mag = p1 - p2;
            sum_neg = an_neg_reg;
        end
        else
        begin
            sum_mag = p2 - p1;
            sum_neg = add_y_neg;
        end

        rn_mag   = '0;
        rd_mag   = PW'(1);
        rn_neg   = 1'b0;
        no_arith = 1'b0;
        div0     = 1'b0;
        unique case (op_reg)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB:
            begin
                rn_mag = sum_mag;
                rn_neg = sum_neg;
                rd_mag = p3;
            end
            rau_pkg::OP_MUL:
            begin
                rn_mag = p4;
                rn_neg = an_neg_reg ^ bn_neg_reg;
                rd_mag = p3;
            end
            rau_pkg::OP_DIV:
            begin
                if (bn_reg == '0)
                begin
                    div0     = 1'b1;
                    no_arith = 1'b1;
                end
                else
                begin
                    rn_mag = p1;
                    rn_neg = an_neg_reg ^ bn_neg_reg;
                    rd_mag = p2;
                end
            end
            default:
            begin
                no_arith = 1'b1;
            end
        endcase

        // value compare of an*bd against bn*ad
        if (an_neg_reg != bn_neg_reg)
        begin
            c_equal = 1'b0;
            c_less  = an_neg_reg;
        end
        else
        begin
            c_equal = (p1 == p2);
            c_less  = an_neg_reg ? (p1 > p2) : (p1 < p2);
        end
    end

    logic          skip_reg, rn_neg_reg;
    logic [1:0]    stat_reg;
    logic          less_reg, equal_reg;
    logic [PW-1:0] rn_mag_reg, rd_mag_reg;

    // binary GCD
    logic [PW-1:0] x_reg, y_reg;
    logic [KW-1:0] k_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.form)
        begin
            skip_reg   <= sts.skip;
            stat_reg   <= div0 ? rau_pkg::ST_DIV0 : rau_pkg::ST_OK;
            less_reg   <= c_less;
            equal_reg  <= c_equal;
            rn_neg_reg <= rn_neg;
            rn_mag_reg <= rn_mag;
            rd_mag_reg <= rd_mag;
            x_reg      <= rn_mag;
            y_reg      <= rd_mag;
            k_reg      <= '0;
        end
        else if (cmd.gcd_step)
        begin
            priority if (!x_reg[0] && !y_reg[0])
            begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!x_reg[0])
                x_reg <= x_reg >> 1;
            else if (!y_reg[0])
                y_reg <= y_reg >> 1;
            else if (x_reg > y_reg)
                x_reg <= x_reg - y_reg;
            else
                y_reg <= y_reg - x_reg;
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [PW-1:0]   quo_reg, dvs_reg, nm_reg;
    logic [PW:0]     rem_reg, div_sh;
    logic [PW+1:0]   div_diff;
    logic [CW-1:0]   cnt_reg;

    assign div_sh   = {rem_reg[PW-1:0], quo_reg[PW-1]};
    assign div_diff = {1'b0, div_sh} - {2'b00, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            if (cmd.div_den)
                nm_reg <= quo_reg;
            quo_reg <= cmd.div_den ? rd_mag_reg : rn_mag_reg;
            rem_reg <= '0;
            dvs_reg <= x_reg << k_reg;
        end
        else if (cmd.div_step)
        begin
            if (!div_diff[PW+1])
            begin
                rem_reg <= div_diff[PW:0];
                quo_reg <= {quo_reg[PW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_sh;
                quo_reg <= {quo_reg[PW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.div_init)
            cnt_reg <= DIV_STEPS;
        else if (cmd.div_step)
            cnt_reg <= cnt_reg - 1'b1;
    end

    // status back to the controller
    always_comb
    begin
        sts.skip     = no_arith || (rn_mag == '0);
        sts.gcd_done = (x_reg == y_reg);
        sts.div_done = (cnt_reg == '0);
    end

    // range check and result register
    logic             in_range;
    logic [WIDTH-1:0] num_w;

    always_comb
    begin
        in_range = (quo_reg <= LIM) && (rn_neg_reg ? (nm_reg <= LIM + 1'b1) : (nm_reg <= LIM));
        num_w    = rn_neg_reg ? (~nm_reg[WIDTH-1:0] + 1'b1) : nm_reg[WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            less    <= less_reg;
            equal   <= equal_reg;
            greater <= !less_reg && !equal_reg;
            if (skip_reg || !in_range)
            begin
                res_num <= '0;
                res_den <= rau_pkg::DEN_W'(1);
                status  <= skip_reg ? stat_reg : rau_pkg::ST_RANGE;
            end
            else
            begin
                res_num <= rau_pkg::DATA_W'($signed(num_w));
                res_den <= rau_pkg::DEN_W'(quo_reg[WIDTH-2:0]);
                status  <= rau_pkg::ST_OK;
            end
        end
    end

endmodule
